/* rtl/pcss_pkg.sv */
`default_nettype none
package pcss_pkg;

   localparam int MAX_SLOT_W = 10;
   localparam int MAX_CLS_W  = 3;

   localparam logic [2:0] EV_QUEUED   = 3'd0;
   localparam logic [2:0] EV_DROPPED  = 3'd1;
   localparam logic [2:0] EV_ANSWERED = 3'd2;
   localparam logic [2:0] EV_BUSY     = 3'd3;
   localparam logic [2:0] EV_IDLE     = 3'd4;

   localparam logic CMD_ARRIVAL = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } pcss_state_type;

   typedef struct packed {
      logic                  push;
      logic                  pop;
      logic [MAX_CLS_W-1:0]  push_cls;
   } pcss_qcmd_type;

   typedef struct packed {
      logic                  push_full;
      logic                  pop_any;
      logic [MAX_CLS_W-1:0]  pop_cls;
      logic [MAX_SLOT_W-1:0] push_slot;
      logic [MAX_SLOT_W-1:0] pop_slot;
   } pcss_qstat_type;

endpackage
`default_nettype wire

/* rtl/priority_class_service_scheduler.sv */
// Strict-priority call scheduler: four FIFO classes, one non-preemptive server.
//
// Input: drive req_* and raise start; the beat is taken at a rising edge where
// start is high and busy is low. req_command 0 is a call arrival, 1 a tick.
// Output: each item yields exactly one result beat, shown on rsp_* for one
// cycle with rsp_valid high. There is no back-pressure on this side.
//
// Flow: arrivals, and ticks that find the server busy or all queues empty,
// give their result in the cycle after acceptance, and busy stays low, so one
// such item per cycle is taken. A tick that answers a call reads the request
// RAM (registered read): busy is high for one cycle, then the result passes
// the RAM read register and the output register; no new item is taken while busy.
//
// Reset (synchronous) empties all queues and clears the busy counter. The
// request RAM needs no clearing; queue counts gate every read of it.
`default_nettype none
module priority_class_service_scheduler
   import pcss_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int CLASS_COUNT = 4,
   parameter int ID_BITS     = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_command,
   input  wire logic [1:0] req_call_class,
   input  wire logic [7:0] req_call_id,
   input  wire logic [7:0] req_call_duration,
   output logic            rsp_valid,
   output logic [2:0]      rsp_event_kind,
   output logic [7:0]      rsp_served_id,
   output logic [1:0]      rsp_served_class,
   output logic [7:0]      rsp_busy_remaining
);

   localparam int SlotW = $clog2(QUEUE_DEPTH);
   localparam int ClsW  = $clog2(CLASS_COUNT);
   localparam int IdW   = (ID_BITS < 8) ? ID_BITS : 8;
   localparam int RamW  = IdW + 8;
   localparam int RamD  = CLASS_COUNT * (2 ** SlotW);
   localparam int AddrW = ClsW + SlotW;

   pcss_state_type  state_ff, state_in;
   pcss_qcmd_type   qcmd;
   pcss_qstat_type  qstat;

   logic            accept;
   logic [ClsW-1:0] cls_sat;
   logic [IdW-1:0]  id_m;
   logic [RamW-1:0] rd_data;
   logic [IdW-1:0]  rd_id;
   logic [7:0]      rd_dur;

   logic            valid_ff, valid_in;
   logic [2:0]      kind_ff, kind_in;
   logic [7:0]      id_ff, id_in;
   logic [1:0]      cls_ff, cls_in;
   logic [7:0]      busy_left_ff, busy_left_in;
   logic [ClsW-1:0] pend_cls_ff, pend_cls_in;

   assign accept  = start && !busy;
   assign cls_sat = (32'(req_call_class) >= CLASS_COUNT) ? ClsW'(CLASS_COUNT - 1)
                                                         : ClsW'(req_call_class);
   assign id_m    = req_call_id[IdW-1:0];
   assign rd_id   = rd_data[RamW-1:8];
   assign rd_dur  = rd_data[7:0];

   pcss_qctl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .CLASS_COUNT (CLASS_COUNT)
   ) u_qctl (
      .clock (clock),
      .reset (reset),
      .qcmd  (qcmd),
      .qstat (qstat)
   );

   pcss_ram #(
      .WIDTH (RamW),
      .DEPTH (RamD)
   ) u_store (
      .clock   (clock),
      .wr_en   (qcmd.push),
      .wr_addr (AddrW'({cls_sat, qstat.push_slot[SlotW-1:0]})),
      .wr_data ({id_m, req_call_duration}),
      .rd_en   (qcmd.pop),
      .rd_addr (AddrW'({qstat.pop_cls[ClsW-1:0], qstat.pop_slot[SlotW-1:0]})),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == CMD_TICK && busy_left_ff == '0 && qstat.pop_any) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy          = (state_ff == ST_READ);
      qcmd.push     = accept && req_command == CMD_ARRIVAL && !qstat.push_full;
      qcmd.pop      = accept && req_command == CMD_TICK && busy_left_ff == '0 && qstat.pop_any;
      qcmd.push_cls = MAX_CLS_W'(cls_sat);
   end

   always_comb begin
      valid_in     = 1'b0;
      kind_in      = kind_ff;
      id_in        = id_ff;
      cls_in       = cls_ff;
      busy_left_in = busy_left_ff;
      pend_cls_in  = pend_cls_ff;
      priority if (state_ff == ST_READ) begin
         valid_in     = 1'b1;
         kind_in      = EV_ANSWERED;
         id_in        = 8'(rd_id);
         cls_in       = 2'(pend_cls_ff);
         busy_left_in = (rd_dur == '0) ? '0 : rd_dur - 8'd1;
      end else if (accept && req_command == CMD_ARRIVAL) begin
         valid_in = 1'b1;
         kind_in  = qstat.push_full ? EV_DROPPED : EV_QUEUED;
         id_in    = 8'(id_m);
         cls_in   = 2'(cls_sat);
      end else if (accept && busy_left_ff != '0) begin
         valid_in     = 1'b1;
         kind_in      = EV_BUSY;
         id_in        = '0;
         cls_in       = '0;
         busy_left_in = busy_left_ff - 8'd1;
      end else if (accept && qstat.pop_any) begin
         pend_cls_in = qstat.pop_cls[ClsW-1:0];
      end else if (accept) begin
         valid_in = 1'b1;
         kind_in  = EV_IDLE;
         id_in    = '0;
         cls_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= 1'b0;
         busy_left_ff <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         busy_left_ff <= busy_left_in;
      end
      kind_ff     <= kind_in;
      id_ff       <= id_in;
      cls_ff      <= cls_in;
      pend_cls_ff <= pend_cls_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_event_kind     = kind_ff;
   assign rsp_served_id      = id_ff;
   assign rsp_served_class   = cls_ff;
   assign rsp_busy_remaining = busy_left_ff;

`ifndef SYNTHESIS
   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_IDLE)
      else $error("read state held more than one cycle");

   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> rsp_valid && rsp_event_kind == EV_ANSWERED)
      else $error("answer beat missing after store read");

   a_busy_decrements: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_BUSY |->
         busy_left_ff == 8'($past(busy_left_ff) - 8'd1))
      else $error("busy counter did not decrement");
`endif

endmodule
`default_nettype wire

/* rtl/pcss_ram.sv */
`default_nettype none
module pcss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/pcss_qctl.sv */
`default_nettype none
module pcss_qctl
   import pcss_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int CLASS_COUNT = 4
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire pcss_qcmd_type  qcmd,
   output pcss_qstat_type      qstat
);

   localparam int SlotW = $clog2(QUEUE_DEPTH);
   localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
   localparam int ClsW  = $clog2(CLASS_COUNT);

   logic [SlotW-1:0] head_ff [CLASS_COUNT];
   logic [SlotW-1:0] head_in [CLASS_COUNT];
   logic [SlotW-1:0] tail_ff [CLASS_COUNT];
   logic [SlotW-1:0] tail_in [CLASS_COUNT];
   logic [CntW-1:0]  cnt_ff  [CLASS_COUNT];
   logic [CntW-1:0]  cnt_in  [CLASS_COUNT];

   logic [ClsW-1:0]  push_idx;
   logic [ClsW-1:0]  pick;
   logic             any;

   function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] p);
      return (p == SlotW'(QUEUE_DEPTH - 1)) ? '0 : p + SlotW'(1);
   endfunction

   assign push_idx = qcmd.push_cls[ClsW-1:0];

   // highest non-empty class wins
   always_comb begin
      pick = '0;
      any  = 1'b0;
      for (int c = 0; c < CLASS_COUNT; c++) begin
         if (cnt_ff[c] != '0) begin
            pick = ClsW'(c);
            any  = 1'b1;
         end
      end
   end

   always_comb begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
         head_in[c] = head_ff[c];
         tail_in[c] = tail_ff[c];
         cnt_in[c]  = cnt_ff[c];
         if (qcmd.push && push_idx == ClsW'(c)) begin
            tail_in[c] = next_slot(tail_ff[c]);
            cnt_in[c]  = cnt_ff[c] + CntW'(1);
         end
         if (qcmd.pop && pick == ClsW'(c)) begin
            head_in[c] = next_slot(head_ff[c]);
            cnt_in[c]  = cnt_ff[c] - CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
         if (reset) begin
            head_ff[c] <= '0;
            tail_ff[c] <= '0;
            cnt_ff[c]  <= '0;
         end else begin
            head_ff[c] <= head_in[c];
            tail_ff[c] <= tail_in[c];
            cnt_ff[c]  <= cnt_in[c];
         end
      end
   end

   always_comb begin
      qstat.push_full = (cnt_ff[push_idx] == CntW'(QUEUE_DEPTH));
      qstat.pop_any   = any;
      qstat.pop_cls   = MAX_CLS_W'(pick);
      qstat.push_slot = MAX_SLOT_W'(tail_ff[push_idx]);
      qstat.pop_slot  = MAX_SLOT_W'(head_ff[pick]);
   end

endmodule
`default_nettype wire
